// File: design/lss_pkg.sv
// ----------------------------------------------------------------------------
// lss_pkg
// shared sizes, command codes and result status codes for the lifo stack
// ----------------------------------------------------------------------------
package lss_pkg;

    localparam int unsigned STACK_DEPTH = 64;
    localparam int unsigned ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int unsigned DATA_W      = 32;
    localparam int unsigned POS_W       = 6;
    localparam int unsigned POS_MAX     = 63;

    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;

    typedef enum logic [2:0] {
        ST_PUSHED = 3'd0,
        ST_FULL   = 3'd1,
        ST_POPPED = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_SEARCH = 3'd4
    } status_t;

endpackage

// File: design/lss_ram.sv
// ----------------------------------------------------------------------------
// lss_ram
// simple dual port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module lss_ram #(
    parameter int unsigned DEPTH  = 64,
    parameter int unsigned WIDTH  = 32,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: design/lss_ctrl.sv
// ----------------------------------------------------------------------------
// lss_ctrl
// command sequencer: fill count, pop read wait and the top-down search walk
// ----------------------------------------------------------------------------
module lss_ctrl import lss_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [1:0]               cmd,
    input  logic signed [DATA_W-1:0] value_in,
    output logic                     busy,
    output logic                     done,
    output status_t                  status,
    output logic signed [DATA_W-1:0] popped_value,
    output logic                     found,
    output logic [POS_W-1:0]         match_position,
    output logic                     ram_wr_en,
    output logic [ADDR_W-1:0]        ram_wr_addr,
    output logic [DATA_W-1:0]        ram_wr_data,
    output logic                     ram_rd_en,
    output logic [ADDR_W-1:0]        ram_rd_addr,
    input  logic [DATA_W-1:0]        ram_rd_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_POP  = 3'b010,
        S_SRCH = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [ADDR_W-1:0]   pos_reg, pos_next;
    logic [DATA_W-1:0]   key_reg, key_next;
    logic                done_reg, done_next;
    status_t             status_reg, status_next;
    logic [DATA_W-1:0]   popped_reg, popped_next;
    logic                found_reg, found_next;
    logic [POS_W-1:0]    mpos_reg, mpos_next;

    logic [CNT_W-1:0]    top_sum;
    logic [CNT_W-1:0]    walk_sum;
    logic [POS_W-1:0]    sat_pos;

    assign top_sum  = count_reg - CNT_W'(1);
    // address of the entry one below the one now being compared
    assign walk_sum = count_reg - CNT_W'(pos_reg) - CNT_W'(2);
    assign sat_pos  = (32'(pos_reg) > POS_MAX) ? POS_W'(POS_MAX) : POS_W'(pos_reg);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        key_next    = key_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        popped_next = popped_reg;
        found_next  = found_reg;
        mpos_next   = mpos_reg;
        ram_wr_en   = 1'b0;
        ram_wr_addr = count_reg[ADDR_W-1:0];
        ram_wr_data = value_in;
        ram_rd_en   = 1'b0;
        ram_rd_addr = top_sum[ADDR_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (cmd)
                        CMD_PUSH:
                        begin
                            done_next   = 1'b1;
                            popped_next = '0;
                            found_next  = 1'b0;
                            mpos_next   = '0;
                            if (count_reg == CNT_W'(STACK_DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                status_next = ST_PUSHED;
                                ram_wr_en   = 1'b1;
                                count_next  = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_EMPTY;
                                popped_next = '0;
                                found_next  = 1'b0;
                                mpos_next   = '0;
                            end
                            else
                            begin
                                ram_rd_en  = 1'b1;
                                count_next = top_sum;
                                state_next = S_POP;
                            end
                        end
                        CMD_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_SEARCH;
                                popped_next = '0;
                                found_next  = 1'b0;
                                mpos_next   = '0;
                            end
                            else
                            begin
                                ram_rd_en  = 1'b1;
                                key_next   = value_in;
                                pos_next   = '0;
                                state_next = S_SRCH;
                            end
                        end
                        default:
                        begin
                            // unused command: no result, no change
                        end
                    endcase
                end
            end
            S_POP:
            begin
                done_next   = 1'b1;
                status_next = ST_POPPED;
                popped_next = ram_rd_data;
                found_next  = 1'b0;
                mpos_next   = '0;
                state_next  = S_IDLE;
            end
            S_SRCH:
            begin
                if (ram_rd_data == key_reg)
                begin
                    done_next   = 1'b1;
                    status_next = ST_SEARCH;
                    popped_next = '0;
                    found_next  = 1'b1;
                    mpos_next   = sat_pos;
                    state_next  = S_IDLE;
                end
                else if (CNT_W'(pos_reg) + CNT_W'(1) == count_reg)
                begin
                    // bottom reached without a match
                    done_next   = 1'b1;
                    status_next = ST_SEARCH;
                    popped_next = '0;
                    found_next  = 1'b0;
                    mpos_next   = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = walk_sum[ADDR_W-1:0];
                    pos_next    = pos_reg + ADDR_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        popped_reg <= popped_next;
        found_reg  <= found_next;
        mpos_reg   <= mpos_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign popped_value   = popped_reg;
    assign found          = found_reg;
    assign match_position = mpos_reg;

endmodule

// File: design/lifo_stack_with_search.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_search
// last-in first-out stack of signed 32-bit words with a top-down search
// ----------------------------------------------------------------------------
// usage:
//   a command transaction is taken at a clock edge where start is high and
//   busy is low: cmd selects push, pop or search, value_in is the word to
//   push or the search key. every push, pop or search gives one result,
//   shown for exactly one cycle while done is high; the unused command code
//   gives none. the receiver cannot stall, so results must be taken as shown.
// command flow:
//   push and the failing cases (full, empty, search on an empty stack) give
//   their result in the cycle after the command and busy stays low, so one
//   command per cycle. a pop holds busy high in a state that waits for the
//   registered ram read. a search reads one entry per cycle from the top
//   down through the single ram read port and stops at the first match, or
//   after the bottom entry when nothing matches; busy is high meanwhile.
// reset:
//   clears the fill count and the sequencer; the ram holds no reset value,
//   entries are only read after a push has written them.
// ----------------------------------------------------------------------------
module lifo_stack_with_search import lss_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [1:0]               cmd,
    input  logic signed [DATA_W-1:0] value_in,
    output logic                     busy,
    output logic                     done,
    output status_t                  status,
    output logic signed [DATA_W-1:0] popped_value,
    output logic                     found,
    output logic [POS_W-1:0]         match_position
);

    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [DATA_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [DATA_W-1:0] ram_rd_data;

    lss_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .cmd            (cmd),
        .value_in       (value_in),
        .busy           (busy),
        .done           (done),
        .status         (status),
        .popped_value   (popped_value),
        .found          (found),
        .match_position (match_position),
        .ram_wr_en      (ram_wr_en),
        .ram_wr_addr    (ram_wr_addr),
        .ram_wr_data    (ram_wr_data),
        .ram_rd_en      (ram_rd_en),
        .ram_rd_addr    (ram_rd_addr),
        .ram_rd_data    (ram_rd_data)
    );

    lss_ram #(
        .DEPTH  (STACK_DEPTH),
        .WIDTH  (DATA_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

`ifndef SYNTHESIS
    // a result only follows an accepted command or a cycle of work
    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(start && !busy) || $past(busy)))
        else $error("result without a pending transaction");

    // a push always gives its result in the next cycle without raising busy
    a_push_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd == CMD_PUSH) |=> (done && !busy))
        else $error("push did not complete in one cycle");

    // search fields stay clear on any other result
    a_search_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_SEARCH) |-> (!found && match_position == '0))
        else $error("search fields set on a non-search result");

    // a found result is always a search result
    a_found_is_search: assert property (@(posedge clk) disable iff (!rst_n)
        (done && found) |-> (status == ST_SEARCH && popped_value == '0))
        else $error("found set outside a search result");
`endif

endmodule

// File: tb/sv/lifo_stack_with_search_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lifo_stack_with_search_test
// drives push, pop, search and unused commands with random gaps, predicts each result
// from a local copy of the stack and checks every done strobe in order
// ----------------------------------------------------------------------------
module lifo_stack_with_search_test;
    import lss_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int unsigned ITEM_TARGET = 1750;
    localparam int unsigned SETTLE_CYCLES = 70;

    typedef struct {
        logic [1:0]               op;
        logic signed [DATA_W-1:0] word;
        int unsigned              gap;
        bit                       drain;
    } stack_cmd_t;

    typedef struct packed {
        status_t                  status;
        logic signed [DATA_W-1:0] popped;
        logic                     hit;
        logic [POS_W-1:0]         pos;
    } stack_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic [1:0]               cmd = CMD_PUSH;
    logic signed [DATA_W-1:0] value_in = '0;
    logic                     busy;
    logic                     done;
    status_t                  status;
    logic signed [DATA_W-1:0] popped_value;
    logic                     found;
    logic [POS_W-1:0]         match_position;

    lifo_stack_with_search dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .cmd            (cmd),
        .value_in       (value_in),
        .busy           (busy),
        .done           (done),
        .status         (status),
        .popped_value   (popped_value),
        .found          (found),
        .match_position (match_position)
    );

    always #5 clk = ~clk;

    stack_cmd_t               pending_cmds[$];
    stack_result_t            expected_results[$];
    logic signed [DATA_W-1:0] gen_stack[$];
    int unsigned              mismatch_count = 0;

    // predicted stack contents
    logic [DATA_W-1:0]        model_words[STACK_DEPTH];
    int unsigned              model_fill = 0;

    // ------------------------------------------------------------------
    // stimulus generation
    // ------------------------------------------------------------------
    task automatic queue_cmd(input logic [1:0] op, input logic signed [DATA_W-1:0] word,
                             input int unsigned gap, input bit drain);
        stack_cmd_t c;
        begin
            c.op = op;
            c.word = word;
            c.gap = gap;
            c.drain = drain;
            pending_cmds.push_back(c);
            // track generated contents so search keys can be picked from the stack
            if (op == CMD_PUSH && gen_stack.size() < STACK_DEPTH)
                gen_stack.push_back(word);
            else if (op == CMD_POP && gen_stack.size() > 0)
                void'(gen_stack.pop_back());
        end
    endtask

    function automatic logic signed [DATA_W-1:0] random_word();
        logic signed [DATA_W-1:0] w;
        begin
            case ($urandom_range(0, 9))
                6, 7: w = $signed($urandom_range(0, 15)) - 8;
                8: begin
                    case ($urandom_range(0, 3))
                        0: w = 32'sh7fff_ffff;
                        1: w = 32'sh8000_0000;
                        2: w = '0;
                        default: w = '1;
                    endcase
                end
                default: w = $urandom();
            endcase
            return w;
        end
    endfunction

    function automatic logic signed [DATA_W-1:0] search_key();
        begin
            if (gen_stack.size() > 0 && $urandom_range(0, 99) < 65)
                return gen_stack[$urandom_range(0, gen_stack.size() - 1)];
            return random_word();
        end
    endfunction

    function automatic int unsigned random_gap(input bit idle_on);
        int unsigned r;
        begin
            r = $urandom_range(0, 99);
            if (!idle_on || r < 70)
                return 0;
            if (r < 95)
                return $urandom_range(1, 3);
            return $urandom_range(8, 40);
        end
    endfunction

    initial
    begin
        int unsigned count;
        int unsigned phase_len;
        int unsigned push_pct;
        int unsigned r;
        bit          idle_on;
        bit          drain_next;
        logic [1:0]  op;

        // directed: extremes, every command, empty and unused cases
        queue_cmd(CMD_PUSH,   32'sh7fff_ffff, 0, 0);
        queue_cmd(CMD_PUSH,   32'sh8000_0000, 0, 0);
        queue_cmd(CMD_SEARCH, 32'sh8000_0000, 0, 0);
        queue_cmd(CMD_SEARCH, 32'sh7fff_ffff, 1, 0);
        queue_cmd(CMD_SEARCH, 32'sd5,         0, 0);
        queue_cmd(CMD_POP,    32'sd0,         0, 0);
        queue_cmd(CMD_POP,    32'sd0,         2, 0);
        queue_cmd(CMD_POP,    32'sd0,         0, 0);
        queue_cmd(CMD_SEARCH, 32'sd0,         0, 0);
        queue_cmd(CMD_UNUSED, '1,             0, 0);
        queue_cmd(CMD_PUSH,   32'sd0,         0, 0);
        queue_cmd(CMD_PUSH,   -32'sd1,        0, 0);
        queue_cmd(CMD_PUSH,   32'sd0,         0, 0);
        queue_cmd(CMD_SEARCH, 32'sd0,         0, 0);
        queue_cmd(CMD_PUSH,   32'sh1234_5678, 0, 0);
        queue_cmd(CMD_SEARCH, 32'sd0,         0, 0);
        queue_cmd(CMD_SEARCH, -32'sd1,        3, 0);
        queue_cmd(CMD_UNUSED, 32'sh5555_aaaa, 0, 0);
        queue_cmd(CMD_POP,    32'sd0,         0, 0);
        queue_cmd(CMD_POP,    32'sd0,         0, 0);
        queue_cmd(CMD_POP,    32'sd0,         0, 0);
        queue_cmd(CMD_POP,    32'sd0,         0, 0);
        queue_cmd(CMD_POP,    32'sd0,         0, 1);
        count = 0;

        // fill to full, search the bottom entry, then push against a full stack
        while (gen_stack.size() < STACK_DEPTH)
        begin
            queue_cmd(CMD_PUSH, random_word(), random_gap(1), 0);
            count++;
        end
        queue_cmd(CMD_SEARCH, gen_stack[0], 0, 0);
        queue_cmd(CMD_PUSH, random_word(), 0, 0);
        queue_cmd(CMD_PUSH, random_word(), 0, 0);
        count += 3;

        drain_next = 1'b1;
        while (count < ITEM_TARGET)
        begin
            phase_len = $urandom_range(40, 150);
            case ($urandom_range(0, 3))
                0: push_pct = 85;
                1: push_pct = 50;
                2: push_pct = 25;
                default: push_pct = 60;
            endcase
            idle_on = ($urandom_range(0, 3) != 0);
            for (int unsigned i = 0; i < phase_len; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 2)
                    op = CMD_UNUSED;
                else if (r < 2 + push_pct * 6 / 10)
                    op = CMD_PUSH;
                else if (r < 2 + push_pct * 6 / 10 + (100 - push_pct) * 6 / 10)
                    op = CMD_POP;
                else
                    op = CMD_SEARCH;
                queue_cmd(op, (op == CMD_SEARCH) ? search_key() : random_word(),
                          random_gap(idle_on), drain_next);
                drain_next = 1'b0;
                if (op != CMD_UNUSED)
                    count++;
            end
            drain_next = ($urandom_range(0, 3) == 0);
        end
    end

    // ------------------------------------------------------------------
    // reset and driver
    // ------------------------------------------------------------------
    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    logic        took_cmd = 1'b0;
    bit          have_staged = 1'b0;
    stack_cmd_t  staged;
    int unsigned gap_left = 0;

    always @(negedge clk)
    begin
        if (rst_n && !(start && !took_cmd))
        begin
            if (!have_staged && pending_cmds.size() > 0)
            begin
                staged = pending_cmds.pop_front();
                have_staged = 1'b1;
                gap_left = staged.gap;
            end
            if (!have_staged)
                start <= 1'b0;
            else if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (staged.drain && expected_results.size() != 0)
                start <= 1'b0;
            else
            begin
                start <= 1'b1;
                cmd <= staged.op;
                value_in <= staged.word;
                have_staged = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // predictor and monitor
    // ------------------------------------------------------------------
    task automatic predict_stack_op(input logic [1:0] op, input logic [DATA_W-1:0] word,
                                    output bit has_result, output stack_result_t res);
        bit hit_seen;
        begin
            res = '{status: ST_PUSHED, popped: '0, hit: 1'b0, pos: '0};
            has_result = 1'b1;
            hit_seen = 1'b0;
            case (op)
                CMD_PUSH:
                begin
                    if (model_fill >= STACK_DEPTH)
                        res.status = ST_FULL;
                    else
                    begin
                        model_words[model_fill] = word;
                        model_fill++;
                    end
                end
                CMD_POP:
                begin
                    if (model_fill == 0)
                        res.status = ST_EMPTY;
                    else
                    begin
                        model_fill--;
                        res.status = ST_POPPED;
                        res.popped = model_words[model_fill];
                    end
                end
                CMD_SEARCH:
                begin
                    res.status = ST_SEARCH;
                    for (int unsigned p = 0; p < model_fill; p++)
                    begin
                        if (!hit_seen && model_words[model_fill - 1 - p] == word)
                        begin
                            hit_seen = 1'b1;
                            res.hit = 1'b1;
                            res.pos = (p > POS_MAX) ? POS_MAX[POS_W-1:0] : p[POS_W-1:0];
                        end
                    end
                end
                default: has_result = 1'b0;
            endcase
        end
    endtask

    task automatic report_mismatch(input string what, input stack_result_t want,
                                   input stack_result_t got);
        begin
            if (mismatch_count < 10)
                $display("%0t: %s: expected status %0d popped %0d found %0d pos %0d, got status %0d popped %0d found %0d pos %0d",
                         $realtime, what, want.status, want.popped, want.hit, want.pos,
                         got.status, got.popped, got.hit, got.pos);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        stack_result_t got;
        stack_result_t want;
        stack_result_t res;
        bit            has_res;
        if (rst_n)
        begin
            // results come out in order, so check before adding this edge's transaction
            if (done)
            begin
                got = '{status: status, popped: popped_value, hit: found,
                        pos: match_position};
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", '0, got);
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                        report_mismatch("result mismatch", want, got);
                end
            end
            if (start && !busy)
            begin
                predict_stack_op(cmd, value_in, has_res, res);
                if (has_res)
                    expected_results.push_back(res);
            end
            took_cmd <= start && !busy;
        end
    end

    // ------------------------------------------------------------------
    // end of run
    // ------------------------------------------------------------------
    initial
    begin
        do
            @(posedge clk);
        while (!(rst_n && pending_cmds.size() == 0 && !have_staged && !start));
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
